// File: src/prlim_pkg.sv
// shared types and constants for the per-client window rate limiter
// no dependencies; imported by every module of the block
`default_nettype none

package prlim_pkg;

	// table size; the slot index is the low bits of client_slot (power of two)
	localparam int CLIENT_SLOTS = 256;
	localparam int SLOT_W       = $clog2(CLIENT_SLOTS);

	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;

	// window periods in seconds
	localparam logic [TIME_W-1:0] MINUTE_PERIOD = 32'd60;
	localparam logic [TIME_W-1:0] HOUR_PERIOD   = 32'd3600;

	// request kinds carried in s_tuser
	localparam logic REQ_CHECK  = 1'b0;
	localparam logic REQ_RECORD = 1'b1;

	// configuration register indexes (word address bit 2)
	localparam logic REG_LIMIT_MINUTE = 1'b0;
	localparam logic REG_LIMIT_HOUR   = 1'b1;

	// one window entry: start time and tally
	typedef struct packed {
		logic [TIME_W-1:0]  start;
		logic [COUNT_W-1:0] tally;
	} win_entry_t;

	// control into one window update
	typedef struct packed {
		logic touch;
		logic is_record;
		logic used;
	} win_req_t;

	// status out of one window update
	typedef struct packed {
		logic used;
		logic full;
	} win_res_t;

endpackage

`default_nettype wire

// File: src/prlim_table.sv
// window table: entry memory with registered read, valid marks, write forwarding
// depends on prlim_pkg
`default_nettype none

module prlim_table
	import prlim_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_slot,
	input  wire logic [SLOT_W-1:0] cur_slot,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_slot,
	input  wire win_entry_t        wr_entry,
	output win_entry_t             rd_entry,
	output logic                   rd_used
);

	win_entry_t              mem [CLIENT_SLOTS];
	win_entry_t              rd_q;
	win_entry_t              fwd_entry_q;
	logic                    fwd_q;
	logic [CLIENT_SLOTS-1:0] used_q;

	// entry memory, read-before-write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_entry;
		end
		if (rd_en) begin
			rd_q        <= mem[rd_slot];
			fwd_entry_q <= wr_entry;
		end
	end

	// forward mark: the read raced a write to the same slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_slot == rd_slot);
		end
	end

	// valid marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr_en) begin
			used_q[wr_slot] <= 1'b1;
		end
	end

	assign rd_entry = fwd_q ? fwd_entry_q : rd_q;
	assign rd_used  = used_q[cur_slot];

	// forwarding only follows a read
	a_fwd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_q) |-> $past(rd_en))
		else $error("forward mark set without a read");

	// a written slot is marked used
	a_used_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> used_q[$past(wr_slot)])
		else $error("written slot not marked used");

endmodule

`default_nettype wire

// File: src/prlim_win.sv
// one window update: restart on expiry, saturating tally, limit compare
// depends on prlim_pkg
`default_nettype none

module prlim_win
	import prlim_pkg::*;
(
	input  wire win_entry_t          old_entry,
	input  wire win_req_t            req,
	input  wire logic [TIME_W-1:0]   now,
	input  wire logic [TIME_W-1:0]   period,
	input  wire logic [COUNT_W-1:0]  limit,
	output win_entry_t               new_entry,
	output win_res_t                 res,
	output logic      [COUNT_W-1:0]  count
);

	logic [TIME_W-1:0]  elapsed;
	logic               expired;
	logic [COUNT_W-1:0] base_tally;
	logic [COUNT_W-1:0] next_tally;

	// restart when never used or the period has run out
	assign elapsed    = now - old_entry.start;
	assign expired    = !req.used || (elapsed >= period);
	assign base_tally = expired ? '0 : old_entry.tally;

	// record counts up to the limit, check leaves the tally
	always_comb begin
		next_tally = base_tally;
		if (req.is_record && (base_tally < limit)) begin
			next_tally = base_tally + COUNT_W'(1);
		end
	end

	always_comb begin
		new_entry = old_entry;
		if (req.touch) begin
			new_entry.start = expired ? now : old_entry.start;
			new_entry.tally = next_tally;
		end
	end

	assign res.used = req.used || req.touch;
	assign res.full = base_tally >= limit;
	assign count    = res.used ? new_entry.tally : '0;

endmodule

`default_nettype wire

// File: src/per_client_window_rate_limiter.sv
// top level: config registers, input stage, two window tables, result register
// depends on prlim_pkg, prlim_table, prlim_win
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: client_slot, now_seconds
// m_*       out  m_tvalid/m_tready  tdata: allowed, minute_count, hour_count
// apb       in   psel/penable       limit_per_minute @0x0, limit_per_hour @0x4
//
// one item per cycle while m_tready does not stall; two register stages, the input stage then the result register
// table reads are registered, a write to the same slot in the same cycle as the read is forwarded
// reset clears the valid marks of all slots at once, no clearing pass
// a stalled result holds the stage behind it; one more transfer fills an empty input stage
`default_nettype none

module per_client_window_rate_limiter
	import prlim_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [7:0] client_slot, [39:8] now_seconds
	input  wire logic [0:0]  s_tuser,   // [0] req_type
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // [0] allowed, [16:1] minute_count, [32:17] hour_count
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [COUNT_W-1:0] lim_min_q;
	logic [COUNT_W-1:0] lim_hour_q;

	logic               valid_s1;
	logic               rec_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [TIME_W-1:0]  now_s1;

	logic               valid_s2;
	logic               rec_s2;
	logic               allowed_s2;
	logic [COUNT_W-1:0] min_cnt_s2;
	logic [COUNT_W-1:0] hour_cnt_s2;

	logic               accept;
	logic               advance;

	win_entry_t         min_old;
	win_entry_t         min_new;
	win_entry_t         hour_old;
	win_entry_t         hour_new;
	logic               min_used;
	logic               hour_used;
	win_req_t           min_req;
	win_req_t           hour_req;
	win_res_t           min_res;
	win_res_t           hour_res;
	logic [COUNT_W-1:0] min_cnt;
	logic [COUNT_W-1:0] hour_cnt;
	logic               min_deny;
	logic               hour_deny;

	// apb register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_min_q  <= '0;
			lim_hour_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_LIMIT_MINUTE: lim_min_q  <= pwdata[COUNT_W-1:0];
				REG_LIMIT_HOUR:   lim_hour_q <= pwdata[COUNT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LIMIT_MINUTE: prdata = {16'b0, lim_min_q};
			REG_LIMIT_HOUR:   prdata = {16'b0, lim_hour_q};
			default:          prdata = '0;
		endcase
	end

	// handshake
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1  <= s_tuser[0];
			slot_s1 <= s_tdata[SLOT_W-1:0];
			now_s1  <= s_tdata[39:8];
		end
	end

	// window tables
	prlim_table u_min_tab (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_slot  (s_tdata[SLOT_W-1:0]),
		.cur_slot (slot_s1),
		.wr_en    (valid_s1 && advance && min_req.touch),
		.wr_slot  (slot_s1),
		.wr_entry (min_new),
		.rd_entry (min_old),
		.rd_used  (min_used)
	);

	prlim_table u_hour_tab (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_slot  (s_tdata[SLOT_W-1:0]),
		.cur_slot (slot_s1),
		.wr_en    (valid_s1 && advance && hour_req.touch),
		.wr_slot  (slot_s1),
		.wr_entry (hour_new),
		.rd_entry (hour_old),
		.rd_used  (hour_used)
	);

	// minute window, then hour window unless the minute check denied
	assign min_req.touch     = (lim_min_q != '0);
	assign min_req.is_record = (rec_s1 == REQ_RECORD);
	assign min_req.used      = min_used;
	assign min_deny          = (rec_s1 == REQ_CHECK) && min_req.touch && min_res.full;

	assign hour_req.touch     = (lim_hour_q != '0) && !min_deny;
	assign hour_req.is_record = (rec_s1 == REQ_RECORD);
	assign hour_req.used      = hour_used;
	assign hour_deny          = (rec_s1 == REQ_CHECK) && hour_req.touch && hour_res.full;

	prlim_win u_min_win (
		.old_entry (min_old),
		.req       (min_req),
		.now       (now_s1),
		.period    (MINUTE_PERIOD),
		.limit     (lim_min_q),
		.new_entry (min_new),
		.res       (min_res),
		.count     (min_cnt)
	);

	prlim_win u_hour_win (
		.old_entry (hour_old),
		.req       (hour_req),
		.now       (now_s1),
		.period    (HOUR_PERIOD),
		.limit     (lim_hour_q),
		.new_entry (hour_new),
		.res       (hour_res),
		.count     (hour_cnt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rec_s2      <= rec_s1;
			allowed_s2  <= !(min_deny || hour_deny);
			min_cnt_s2  <= min_cnt;
			hour_cnt_s2 <= hour_cnt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, hour_cnt_s2, min_cnt_s2, allowed_s2};

	// a record always allows
	a_record_allows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (rec_s2 == REQ_RECORD)) |-> allowed_s2)
		else $error("record result denied");

	// taking a transfer behind a full stage means that stage moves on
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> advance)
		else $error("input stage overwritten");

endmodule

`default_nettype wire

// File: tb/tb_per_client_window_rate_limiter.sv
// self-checking testbench for the per-client window rate limiter
// depends on prlim_pkg and per_client_window_rate_limiter; checks every verdict and window count
`default_nettype none

module tb_per_client_window_rate_limiter;
	import prlim_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int HOT_SLOTS   = 6;
	localparam int WIN_MINUTE  = 0;
	localparam int WIN_HOUR    = 1;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one admission request as offered on the input stream
	typedef struct {
		logic              req;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now;
		bit                hold_off;   // sender waits until all verdicts are back
	} admit_req_t;

	// one verdict, laid out as on m_tdata
	typedef struct packed {
		logic [COUNT_W-1:0] hour_count;
		logic [COUNT_W-1:0] minute_count;
		logic               allowed;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;    // [7:0] client_slot, [39:8] now_seconds
	logic [0:0]  s_tuser = '0;    // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [0] allowed, [16:1] minute_count, [32:17] hour_count
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	per_client_window_rate_limiter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predictor state: limits and both window tables
	logic [COUNT_W-1:0] lim [2] = '{16'h0, 16'h0};
	bit                 win_used  [2][CLIENT_SLOTS];
	logic [TIME_W-1:0]  win_start [2][CLIENT_SLOTS];
	logic [COUNT_W-1:0] win_tally [2][CLIENT_SLOTS];

	admit_req_t pending_q [$];
	verdict_t   verdict_q [$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_go = 1'b0;
	bit  s_taken = 1'b0;
	int  hold_cycles;
	int  errors = 0;
	int  transfers_in = 0;
	int  verdicts_seen = 0;
	int  denials_seen = 0;
	int  settings_used = 0;
	int  cycle_cnt = 0;
	logic [TIME_W-1:0] wall = '0;
	logic [SLOT_W-1:0] hot [HOT_SLOTS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// restart a window that was never used or whose period has run out
	function automatic void touch_window(int w, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] span;
		span = (w == WIN_MINUTE) ? MINUTE_PERIOD : HOUR_PERIOD;
		if (!win_used[w][s] || (now - win_start[w][s]) >= span) begin
			win_used[w][s] = 1'b1;
			win_start[w][s] = now;
			win_tally[w][s] = '0;
		end
	endfunction

	// verdict and counts for one request, updating the tables
	function automatic verdict_t predict_admission(admit_req_t r);
		verdict_t v;
		v.allowed = 1'b1;
		if (lim[WIN_MINUTE] != 0 || lim[WIN_HOUR] != 0) begin
			// hour window is skipped once the minute window denies a check
			for (int w = WIN_MINUTE; w <= WIN_HOUR; w++) begin
				if (lim[w] != 0 && v.allowed) begin
					touch_window(w, r.slot, r.now);
					if (r.req == REQ_RECORD) begin
						if (win_tally[w][r.slot] < lim[w])
							win_tally[w][r.slot] = win_tally[w][r.slot] + 1'b1;
					end else if (win_tally[w][r.slot] >= lim[w]) begin
						v.allowed = 1'b0;
					end
				end
			end
		end
		v.minute_count = win_used[WIN_MINUTE][r.slot] ? win_tally[WIN_MINUTE][r.slot] : '0;
		v.hour_count   = win_used[WIN_HOUR][r.slot] ? win_tally[WIN_HOUR][r.slot] : '0;
		return v;
	endfunction

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
				verdict_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// input driver: next request or idle filler at a falling edge once the last one is taken or none is offered
	always @(negedge clk) begin : feed
		admit_req_t r;
		if (arst_n && (s_taken || !s_tvalid)) begin
			s_taken = 1'b0;
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				!(pending_q[0].hold_off && verdict_q.size() != 0)) begin
				r = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.req;
				s_tdata  <= {r.now, r.slot};
			end else begin
				s_tvalid <= 1'b0;
				s_tuser  <= 1'($urandom);
				s_tdata  <= {$urandom, 8'($urandom)};
			end
		end
	end

	// input transfer: predict the verdict from the pins
	always @(posedge clk) begin : take
		admit_req_t r;
		if (arst_n && s_tvalid && s_tready) begin
			r.req = s_tuser[0];
			r.slot = s_tdata[7:0];
			r.now = s_tdata[39:8];
			r.hold_off = 1'b0;
			verdict_q.push_back(predict_admission(r));
			s_taken = 1'b1;
			transfers_in++;
		end
	end

	// long receiver hold-off, counted here
	always begin
		wait (hold_go);
		for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
			@(posedge clk);
		hold_go = 1'b0;
	end

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= !hold_go && ($urandom_range(99) >= recv_stall_pct);
	end

	// result transfer: compare against the oldest prediction
	always @(posedge clk) begin : check_out
		verdict_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[32:0];
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result allowed=%0d minute=%0d hour=%0d", $time,
					got.allowed, got.minute_count, got.hour_count);
			end else begin
				want = verdict_q.pop_front();
				if (!want.allowed)
					denials_seen++;
				if (got.allowed !== want.allowed || got.minute_count !== want.minute_count ||
					got.hour_count !== want.hour_count) begin
					errors++;
					$display("%0t: mismatch expected allowed=%0d minute=%0d hour=%0d, got allowed=%0d minute=%0d hour=%0d",
						$time, want.allowed, want.minute_count, want.hour_count,
						got.allowed, got.minute_count, got.hour_count);
				end
			end
		end
	end

	task automatic queue_request(logic req, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] now,
		bit hold_off = 1'b0);
		admit_req_t r;
		r.req = req;
		r.slot = slot;
		r.now = now;
		r.hold_off = hold_off;
		pending_q.push_back(r);
	endtask

	// random traffic: mostly a few busy clients on a slowly moving clock
	task automatic queue_traffic(int n);
		int pick;
		logic [TIME_W-1:0] t;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick >= 97)
				wall = wall + $urandom_range(1000, 5000);
			else if (pick >= 90)
				wall = wall + $urandom_range(31, 120);
			else if (pick >= 70)
				wall = wall + $urandom_range(1, 30);
			t = ($urandom_range(99) < 5) ? $urandom : wall;
			queue_request(($urandom_range(99) < 55) ? REQ_RECORD : REQ_CHECK,
				($urandom_range(99) < 80) ? hot[$urandom_range(HOT_SLOTS - 1)] : 8'($urandom),
				t);
		end
	endtask

	// wait until every request is sent and every verdict is back
	task automatic settle();
		while (pending_q.size() != 0 || verdict_q.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	// register write then read back over the config port
	task automatic write_limit(logic sel, logic [COUNT_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		lim[sel] = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0, val}) begin
			errors++;
			$display("%0t: readback of register %0d expected %0d, got %0d", $time, sel, val,
				prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// drain, program both limits, pick the idling mode
	task automatic start_setting(logic [COUNT_W-1:0] lm, logic [COUNT_W-1:0] lh,
		idle_mode_t mode);
		settle();
		write_limit(REG_LIMIT_MINUTE, lm);
		write_limit(REG_LIMIT_HOUR, lh);
		settings_used++;
		case (mode)
			IDLE_SEND: begin
				send_idle_pct = 59;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 59;
			end
			IDLE_BOTH: begin
				send_idle_pct = 19;
				recv_stall_pct = 19;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	initial begin : stimulus
		logic [COUNT_W-1:0] rnd_lm [8];
		logic [COUNT_W-1:0] rnd_lh [8];
		rnd_lm = '{16'd65535, 16'd4, 16'd2, 16'd1, 16'd0, 16'd0, 16'd3, 16'd0};
		rnd_lh = '{16'd65535, 16'd9, 16'd1, 16'd0, 16'd3, 16'd0, 16'd5, 16'd0};
		rnd_lm[7] = $urandom_range(1, 6);
		rnd_lh[7] = $urandom_range(0, 8);
		hot[0] = 8'd0;
		hot[1] = 8'd255;
		for (int i = 2; i < HOT_SLOTS; i++)
			hot[i] = 8'($urandom);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// both limits zero out of reset: everything allowed, nothing counted
		queue_request(REQ_CHECK, 8'd0, 32'd0);
		queue_request(REQ_RECORD, 8'd255, 32'hFFFF_FFFF);
		queue_request(REQ_CHECK, 8'd255, 32'hFFFF_FFFF);

		// both windows on: saturation, minute deny leaves hour alone, expiry, wrap
		start_setting(16'd2, 16'd3, IDLE_NONE);
		queue_request(REQ_RECORD, 8'd5, 32'd100);
		queue_request(REQ_CHECK, 8'd5, 32'd100);
		queue_request(REQ_RECORD, 8'd5, 32'd110);
		queue_request(REQ_CHECK, 8'd5, 32'd120);
		queue_request(REQ_RECORD, 8'd5, 32'd125);
		queue_request(REQ_CHECK, 8'd5, 32'd159);
		queue_request(REQ_CHECK, 8'd5, 32'd160);
		queue_request(REQ_CHECK, 8'd5, 32'd3700);
		queue_request(REQ_RECORD, 8'd255, 32'hFFFF_FFF0);
		queue_request(REQ_CHECK, 8'd255, 32'h0000_002B);
		queue_request(REQ_CHECK, 8'd255, 32'h0000_002C);

		// minute window disabled
		start_setting(16'd0, 16'd1, IDLE_NONE);
		queue_request(REQ_CHECK, 8'd7, 32'd5000);
		queue_request(REQ_RECORD, 8'd7, 32'd5000);
		queue_request(REQ_CHECK, 8'd7, 32'd5001);
		queue_request(REQ_CHECK, 8'd5, 32'd5002);

		// hour window disabled, limit of one
		start_setting(16'd1, 16'd0, IDLE_NONE);
		queue_request(REQ_RECORD, 8'd9, 32'd6000);
		queue_request(REQ_CHECK, 8'd9, 32'd6000);
		queue_request(REQ_RECORD, 8'd9, 32'd6059);
		queue_request(REQ_CHECK, 8'd9, 32'hFFFF_FFFF);

		// random traffic under a series of limit settings
		wall = $urandom;
		for (int p = 0; p < 8; p++) begin
			start_setting(rnd_lm[p], rnd_lh[p], idle_mode_t'(p % 4));
			if (p == 4)
				wall = 32'hFFFF_FF00;
			if (p == 5)
				for (int i = 2; i < HOT_SLOTS; i++)
					hot[i] = 8'($urandom);
			if (p == 2) begin
				// receiver holds off while the sender keeps pushing
				@(posedge clk);
				hold_go = 1'b1;
			end
			if (p == 1) begin
				// sender pauses mid-stream until all verdicts are in
				queue_traffic(40);
				queue_request(REQ_CHECK, hot[0], wall, 1'b1);
				queue_traffic(45);
			end else begin
				queue_traffic(85);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("%0d requests sent, %0d verdicts checked, %0d denials", transfers_in,
			verdicts_seen, denials_seen);
		$display("%0d limit settings, idle/stall phases, long hold-off and minute/hour expiry",
			settings_used);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
